FILE: rtl/wmct_pkg.sv
// Shared types, constants and command/status structs for the window mode count tracker.
package wmct_pkg;

  // Table sizes
  localparam int VALUE_RANGE     = 4096;
  localparam int WINDOW_CAPACITY = 4096;
  localparam int VAL_W           = 12;
  localparam int OUT_W           = 13;
  localparam int VC_AW           = $clog2(VALUE_RANGE);
  localparam int CNT_W           = $clog2(WINDOW_CAPACITY + 1);
  localparam int COC_DEPTH       = WINDOW_CAPACITY + 1;
  localparam int COC_AW          = $clog2(COC_DEPTH);

  // Item commands
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } wmct_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VC,
    ST_C1,
    ST_C2
  } wmct_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr;
    logic accept;
    logic vc_step;
    logic c1_step;
    logic finish;
  } wmct_dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } wmct_dp_sts_t;

endpackage

FILE: rtl/wmct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wmct_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/wmct_ctrl.sv
// Sequencer for table clearing and the per-word read-modify-write steps.
module wmct_ctrl
  import wmct_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  wmct_dp_sts_t sts,
  output wmct_dp_cmd_t cmd
);

  wmct_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid)     state_nxt = ST_VC;
      ST_VC:    state_nxt = ST_C1;
      ST_C1:    state_nxt = ST_C2;
      ST_C2:    if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_VC:   cmd.vc_step = 1'b1;
      ST_C1:   cmd.c1_step = 1'b1;
      ST_C2:   cmd.finish  = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/wmct_dp.sv
// Datapath: count tables, mode and occupancy registers, result register.
module wmct_dp
  import wmct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  wmct_dp_cmd_t     cmd,
  output wmct_dp_sts_t     sts,
  input  logic             in_cmd,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_max_count,
  output logic [OUT_W-1:0] out_window_size,
  output logic             out_rejected
);

  logic              cmd_r;
  logic [VAL_W-1:0]  value_r;
  logic [CNT_W-1:0]  before_r;
  logic              rej_r;
  logic              top_drop_r;
  logic [CNT_W-1:0]  top_r, top_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [COC_AW-1:0] clr_cnt_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_max_r, out_size_r;
  logic              out_rej_r;

  logic              vc_we, vc_re;
  logic [VC_AW-1:0]  vc_waddr, vc_raddr;
  logic [CNT_W-1:0]  vc_wdata, vc_rdata;
  logic              coc_we, coc_re;
  logic [COC_AW-1:0] coc_waddr, coc_raddr;
  logic [CNT_W-1:0]  coc_wdata, coc_rdata;

  logic              is_add;
  logic              in_range;
  logic              rej_now;
  logic [CNT_W-1:0]  before_inc, before_dec;
  logic [COC_AW-1:0] addr2;

  assign is_add     = (cmd_r == CMD_ADD);
  assign in_range   = (32'(value_r) < 32'(VALUE_RANGE));
  assign before_inc = before_r + CNT_W'(1);
  assign before_dec = before_r - CNT_W'(1);
  assign addr2      = COC_AW'(is_add ? before_inc : before_dec);

  // Refuse out-of-range value, add to full window, remove of absent value
  assign rej_now = !in_range
                || (is_add && (occ_r == CNT_W'(WINDOW_CAPACITY)))
                || (!is_add && (vc_rdata == '0));

  // Per-value count table port control
  always_comb begin
    vc_re    = cmd.accept;
    vc_raddr = in_value[VC_AW-1:0];
    vc_we    = 1'b0;
    vc_waddr = value_r[VC_AW-1:0];
    vc_wdata = is_add ? vc_rdata + CNT_W'(1) : vc_rdata - CNT_W'(1);
    if (cmd.clr) begin
      vc_we    = (32'(clr_cnt_r) < 32'(VALUE_RANGE));
      vc_waddr = clr_cnt_r[VC_AW-1:0];
      vc_wdata = '0;
    end else if (cmd.vc_step) begin
      vc_we = !rej_now;
    end
  end

  // Count-of-counts table port control
  always_comb begin
    coc_re    = 1'b0;
    coc_raddr = COC_AW'(vc_rdata);
    coc_we    = 1'b0;
    coc_waddr = COC_AW'(before_r);
    coc_wdata = coc_rdata - CNT_W'(1);
    if (cmd.clr) begin
      coc_we    = 1'b1;
      coc_waddr = clr_cnt_r;
      coc_wdata = '0;
    end else if (cmd.vc_step) begin
      coc_re = !rej_now;
    end else if (cmd.c1_step) begin
      // Drop the old bucket, fetch the neighbor bucket
      coc_we    = !rej_r && (before_r != '0);
      coc_re    = !rej_r;
      coc_raddr = addr2;
    end else if (cmd.finish) begin
      // Bump the new bucket; bucket zero is not tracked
      coc_we    = !rej_r && (is_add || (before_r > CNT_W'(1)));
      coc_waddr = addr2;
      coc_wdata = coc_rdata + CNT_W'(1);
    end
  end

  wmct_ram #(
    .WIDTH (CNT_W),
    .DEPTH (VALUE_RANGE)
  ) u_vc_ram (
    .clk   (clk),
    .we    (vc_we),
    .waddr (vc_waddr),
    .wdata (vc_wdata),
    .re    (vc_re),
    .raddr (vc_raddr),
    .rdata (vc_rdata)
  );

  wmct_ram #(
    .WIDTH (CNT_W),
    .DEPTH (COC_DEPTH)
  ) u_coc_ram (
    .clk   (clk),
    .we    (coc_we),
    .waddr (coc_waddr),
    .wdata (coc_wdata),
    .re    (coc_re),
    .raddr (coc_raddr),
    .rdata (coc_rdata)
  );

  // Latch the word and per-item intermediate values
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
    end
    if (cmd.vc_step) begin
      before_r <= vc_rdata;
      rej_r    <= rej_now;
    end
    if (cmd.c1_step) begin
      top_drop_r <= !is_add && (before_r == top_r) && (coc_rdata == CNT_W'(1));
    end
  end

  // Next mode count and occupancy
  always_comb begin
    top_nxt = top_r;
    occ_nxt = occ_r;
    if (!rej_r) begin
      if (is_add) begin
        occ_nxt = occ_r + CNT_W'(1);
        if (before_inc > top_r) begin
          top_nxt = before_inc;
        end
      end else begin
        occ_nxt = occ_r - CNT_W'(1);
        if (top_drop_r) begin
          top_nxt = top_r - CNT_W'(1);
        end
      end
    end
  end

  // Control state: clear sweep counter, mode count, occupancy, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      top_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + COC_AW'(1);
      end
      if (cmd.finish) begin
        top_r <= top_nxt;
        occ_r <= occ_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_max_r  <= OUT_W'(top_nxt);
      out_size_r <= OUT_W'(occ_nxt);
      out_rej_r  <= rej_r;
    end
  end

  assign sts.clr_last = (clr_cnt_r == COC_AW'(COC_DEPTH - 1));
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_max_count   = out_max_r;
  assign out_window_size = out_size_r;
  assign out_rejected    = out_rej_r;

endmodule

FILE: rtl/window_mode_count_tracker.sv
// Top level: sliding-window mode frequency tracker.
// A word accepted in ST_IDLE passes ST_VC and ST_C1 to ST_C2, which registers
// its result once the prior result is taken; no word is accepted before then,
// as the single-port-read count-of-counts RAM needs two read-modify-writes
// after the per-value count read. Reset: synchronous active-low rst_n starts a
// pass that zeroes both count tables; in_ready stays low until it is done.
module window_mode_count_tracker
  import wmct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_max_count,
  output logic [OUT_W-1:0] out_window_size,
  output logic             out_rejected
);

  wmct_dp_cmd_t dp_cmd;
  wmct_dp_sts_t dp_sts;

  wmct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  wmct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_max_count   (out_max_count),
    .out_window_size (out_window_size),
    .out_rejected    (out_rejected)
  );

endmodule
